/* rtl/prl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package prl_pkg;

    localparam int LIST_DEPTH  = 8;
    localparam int ID_BITS     = 16;
    localparam int ACTION_BITS = 2;
    localparam int COUNT_BITS  = $clog2(LIST_DEPTH + 1);
    localparam int POS_BITS    = $clog2(LIST_DEPTH);

    localparam logic [ACTION_BITS-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_MOVE   = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_REMOVE = 2'd2;

    typedef struct packed {
        logic load;
        logic find;
        logic apply;
    } dp_cmd_t;

endpackage

`default_nettype wire

/* rtl/prl_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module prl_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire prl_pkg::dp_cmd_t                 cmd,
    input  wire logic [prl_pkg::ACTION_BITS-1:0]  action,
    input  wire logic [prl_pkg::ID_BITS-1:0]      pane_id,
    output logic                                  was_present,
    output logic                                  evicted,
    output logic [prl_pkg::ID_BITS-1:0]           newest_id,
    output logic                                  list_empty,
    output logic [prl_pkg::COUNT_BITS-1:0]        entry_count
);
    import prl_pkg::*;

    logic [ACTION_BITS-1:0] action_reg;
    logic [ID_BITS-1:0]     id_reg;
    logic                   hit_reg;
    logic                   hit_next;
    logic [POS_BITS-1:0]    pos_reg;
    logic [POS_BITS-1:0]    pos_next;
    logic [ID_BITS-1:0]     entries_reg [LIST_DEPTH];
    logic [ID_BITS-1:0]     entries_next [LIST_DEPTH];
    logic [ID_BITS-1:0]     above [LIST_DEPTH];
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  count_next;
    logic                   was_present_reg;
    logic                   evicted_reg;

    logic                   is_add;
    logic                   is_move;
    logic                   is_remove;
    logic                   do_append;
    logic                   do_delete;
    logic                   del_mid;
    logic                   evict;
    logic                   full;
    logic [POS_BITS-1:0]    del_pos;
    logic [COUNT_BITS-1:0]  cnt_del;
    logic [COUNT_BITS-1:0]  top_idx;
    logic [COUNT_BITS-1:0]  newest_idx;
    logic [LIST_DEPTH-1:0]  match;

    // operand latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            id_reg     <= pane_id;
        end
    end

    // oldest valid match
    always_comb
    begin
        hit_next = 1'b0;
        pos_next = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            match[i] = (COUNT_BITS'(i) < count_reg) && (entries_reg[i] == id_reg);
        end
        for (int i = LIST_DEPTH - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_next = 1'b1;
                pos_next = POS_BITS'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.find)
        begin
            hit_reg <= hit_next;
            pos_reg <= pos_next;
        end
    end

    genvar g;
    generate
        for (g = 0; g < LIST_DEPTH; g++)
        begin : g_above
            if (g < LIST_DEPTH - 1)
            begin : g_mid
                assign above[g] = entries_reg[g+1];
            end
            else
            begin : g_top
                assign above[g] = '0;
            end
        end
    endgenerate

    // delete then append
    always_comb
    begin
        is_add     = (action_reg == ACT_ADD);
        is_move    = (action_reg == ACT_MOVE);
        is_remove  = (action_reg == ACT_REMOVE);
        do_append  = is_add || is_move;
        full       = (count_reg == COUNT_BITS'(LIST_DEPTH));
        del_mid    = hit_reg && (is_move || is_remove);
        evict      = do_append && full && !del_mid;
        do_delete  = del_mid || evict;
        del_pos    = evict ? '0 : pos_reg;
        cnt_del    = count_reg - COUNT_BITS'(do_delete);
        count_next = cnt_del + COUNT_BITS'(do_append);
        top_idx    = count_reg - COUNT_BITS'(1);
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (do_append && (COUNT_BITS'(i) == cnt_del))
                entries_next[i] = id_reg;
            else if (do_delete && (COUNT_BITS'(i) == top_idx))
                entries_next[i] = '0;
            else if (do_delete && (POS_BITS'(i) >= del_pos) && (COUNT_BITS'(i) < top_idx))
                entries_next[i] = above[i];
            else
                entries_next[i] = entries_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            was_present_reg <= 1'b0;
            evicted_reg     <= 1'b0;
            for (int i = 0; i < LIST_DEPTH; i++)
            begin
                entries_reg[i] <= '0;
            end
        end
        else if (cmd.apply)
        begin
            count_reg       <= count_next;
            was_present_reg <= hit_reg;
            evicted_reg     <= evict;
            for (int i = 0; i < LIST_DEPTH; i++)
            begin
                entries_reg[i] <= entries_next[i];
            end
        end
    end

    assign newest_idx  = count_reg - COUNT_BITS'(1);
    assign list_empty  = (count_reg == '0);
    assign newest_id   = list_empty ? '0 : entries_reg[newest_idx[POS_BITS-1:0]];
    assign entry_count = count_reg;
    assign was_present = was_present_reg;
    assign evicted     = evicted_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(LIST_DEPTH))
        else $error("entry count above depth");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        evicted_reg |-> count_reg == COUNT_BITS'(LIST_DEPTH))
        else $error("eviction reported on a list that is not full");

    a_free_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != COUNT_BITS'(LIST_DEPTH)) |-> entries_reg[LIST_DEPTH-1] == '0)
        else $error("free top slot not cleared");

endmodule

`default_nettype wire

/* rtl/prl_controller.sv */
`timescale 1ns / 1ps
`default_nettype none

module prl_controller (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    output logic               done,
    output prl_pkg::dp_cmd_t   cmd
);
    import prl_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_FIND   = 2'd1;
    localparam logic [1:0] S_APPLY  = 2'd2;
    localparam logic [1:0] S_REPORT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    always_comb
    begin
        accept = start && (state_reg inside {S_IDLE, S_REPORT});
        case (state_reg)
            S_IDLE:   state_next = accept ? S_FIND : S_IDLE;
            S_FIND:   state_next = S_APPLY;
            S_APPLY:  state_next = S_REPORT;
            S_REPORT: state_next = accept ? S_FIND : S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy      = (state_reg == S_FIND) || (state_reg == S_APPLY);
    assign done      = (state_reg == S_REPORT);
    assign cmd.load  = accept;
    assign cmd.find  = (state_reg == S_FIND);
    assign cmd.apply = (state_reg == S_APPLY);

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result not reported three cycles after accept");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_apply_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |=> done && !busy)
        else $error("update not followed by result strobe");

endmodule

`default_nettype wire

/* rtl/pane_recency_list.sv */
`timescale 1ns / 1ps
`default_nettype none

// pane_recency_list: most-recently-used list of pane identifiers, oldest first
// command channel: a word (action, pane_id) is taken at a rising edge with
//   start high and busy low
// actions: add as newest, move to newest, remove; move of an absent id acts as add
// result channel: done is high for exactly one cycle with was_present, evicted,
//   newest_id, list_empty and entry_count valid; the receiver cannot stall it
// done rises after the find and apply states that follow the accepting edge
// a new word is refused while busy is high; one may be taken while done is high
// the steps are a match search over all slots, then one shift and append update
// reset clears the list to empty and the controller to idle, with done low

module pane_recency_list (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [prl_pkg::ACTION_BITS-1:0]  action,
    input  wire logic [prl_pkg::ID_BITS-1:0]      pane_id,
    output logic                                  done,
    output logic                                  was_present,
    output logic                                  evicted,
    output logic [prl_pkg::ID_BITS-1:0]           newest_id,
    output logic                                  list_empty,
    output logic [prl_pkg::COUNT_BITS-1:0]        entry_count
);
    import prl_pkg::*;

    dp_cmd_t cmd;

    prl_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    prl_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .action      (action),
        .pane_id     (pane_id),
        .was_present (was_present),
        .evicted     (evicted),
        .newest_id   (newest_id),
        .list_empty  (list_empty),
        .entry_count (entry_count)
    );

endmodule

`default_nettype wire
